// File: rtl/ioa_pkg.sv
package ioa_pkg;

    localparam int ENTRY_W             = 31;
    localparam int CHROM_W             = 16;
    localparam int INDEX_W             = 6;
    localparam int COUNT_W             = 7;
    localparam int TABLE_DEPTH_DEFAULT = 64;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic [ENTRY_W-1:0] ent_start;
        logic [ENTRY_W-1:0] ent_stop;
        logic [ENTRY_W-1:0] ent_id;
    } entry_t;

    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [ENTRY_W-1:0] start;
        logic [ENTRY_W-1:0] stop;
        logic [ENTRY_W-1:0] id;
        logic               last;
    } result_t;

    typedef struct packed {
        logic    valid;
        result_t data;
    } push_t;

    // strict tests: region spans entry start, sits inside the entry, or spans entry end
    function automatic logic overlaps(
        input logic [ENTRY_W-1:0] rs,
        input logic [ENTRY_W-1:0] re,
        input logic [ENTRY_W-1:0] as,
        input logic [ENTRY_W-1:0] ae
    );
        overlaps = ((rs < as) && (re > as)) ||
                   ((rs > as) && (re < ae)) ||
                   ((rs < ae) && (re > ae));
    endfunction

endpackage

// File: rtl/ioa_if.sv
interface ioa_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [ioa_pkg::INDEX_W-1:0] entry_index;
    logic [ioa_pkg::ENTRY_W-1:0] range_start;
    logic [ioa_pkg::ENTRY_W-1:0] range_end;
    logic [ioa_pkg::ENTRY_W-1:0] annotation_id;
    logic [ioa_pkg::CHROM_W-1:0] region_chrom;

    modport source (
        output valid, mode, entry_index, range_start, range_end, annotation_id,
               region_chrom,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, range_start, range_end, annotation_id,
               region_chrom,
        output ready
    );
endinterface

interface ioa_out_if;
    logic                        valid;
    logic                        ready;
    logic [ioa_pkg::CHROM_W-1:0] out_chrom;
    logic [ioa_pkg::ENTRY_W-1:0] out_start;
    logic [ioa_pkg::ENTRY_W-1:0] out_end;
    logic [ioa_pkg::ENTRY_W-1:0] out_id;
    logic                        last_match;

    modport source (
        output valid, out_chrom, out_start, out_end, out_id, last_match,
        input  ready
    );
    modport sink (
        input  valid, out_chrom, out_start, out_end, out_id, last_match,
        output ready
    );
endinterface

// File: rtl/interval_overlap_annotator_top.sv
// Load transfer: the slot is written at the accepting edge.
// Query transfer: scans N = min(entry_count, TABLE_DEPTH) slots, one read per cycle from the
// table's read port while the result side does not stall; input is ready again once the
// scan and flush are done, or at once when N is 0. A result leaves one match late (the last
// is held to carry the last mark), via a one-deep output register.
// Reset clears control state and entry_count; table contents are undefined until loaded.
module interval_overlap_annotator_top #(
    parameter int TABLE_DEPTH = ioa_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ioa_pkg::COUNT_W-1:0] cfg_wr_data,
    ioa_in_if.sink                      item,
    ioa_out_if.source                   match
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    logic            wr_en;
    logic [IDX_W-1:0] wr_addr;
    ioa_pkg::entry_t wr_data;
    logic            rd_en;
    logic [IDX_W-1:0] rd_addr;
    ioa_pkg::entry_t rd_data;
    logic            out_free;
    ioa_pkg::push_t  push;

    ioa_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ioa_scan #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item        (item),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_free    (out_free),
        .push        (push)
    );

    ioa_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .out_free (out_free),
        .match    (match)
    );

endmodule

// File: rtl/ioa_table.sv
module ioa_table #(
    parameter int TABLE_DEPTH = ioa_pkg::TABLE_DEPTH_DEFAULT,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  ioa_pkg::entry_t  wr_data,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output ioa_pkg::entry_t  rd_data
);

    ioa_pkg::entry_t mem [0:TABLE_DEPTH-1];
    ioa_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/ioa_scan.sv
module ioa_scan #(
    parameter int TABLE_DEPTH = ioa_pkg::TABLE_DEPTH_DEFAULT,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [ioa_pkg::COUNT_W-1:0] cfg_wr_data,
    ioa_in_if.sink                      item,
    output logic                        wr_en,
    output logic [IDX_W-1:0]            wr_addr,
    output ioa_pkg::entry_t             wr_data,
    output logic                        rd_en,
    output logic [IDX_W-1:0]            rd_addr,
    input  ioa_pkg::entry_t             rd_data,
    input  logic                        out_free,
    output ioa_pkg::push_t              push
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [ioa_pkg::COUNT_W-1:0] count_reg;
    logic [CNT_W-1:0]            limit_reg, limit_next;
    logic [CNT_W-1:0]            issue_reg, issue_next;
    logic                        cmp_valid_reg, cmp_valid_next;
    logic                        hold_valid_reg, hold_valid_next;
    logic [ioa_pkg::ENTRY_W-1:0] hold_id_reg, hold_id_next;
    logic [ioa_pkg::ENTRY_W-1:0] q_start_reg, q_stop_reg;
    logic [ioa_pkg::CHROM_W-1:0] q_chrom_reg;

    logic             accept;
    logic             hit;
    logic             stall;
    logic             issue_more;
    logic [CNT_W-1:0] clamp;

    assign item.ready = (state_reg == ST_IDLE);
    assign accept     = item.valid && item.ready;

    assign clamp = (count_reg > ioa_pkg::COUNT_W'(TABLE_DEPTH)) ?
                   CNT_W'(TABLE_DEPTH) : CNT_W'(count_reg);

    assign wr_en   = accept && (item.mode == ioa_pkg::MODE_LOAD) &&
                     (ioa_pkg::COUNT_W'(item.entry_index) < ioa_pkg::COUNT_W'(TABLE_DEPTH));
    assign wr_addr = item.entry_index[IDX_W-1:0];
    assign wr_data = '{ent_start: item.range_start,
                       ent_stop:  item.range_end,
                       ent_id:    item.annotation_id};

    assign hit = ioa_pkg::overlaps(q_start_reg, q_stop_reg, rd_data.ent_start,
                                   rd_data.ent_stop);
    // a second hit with the held one still unsent must wait for the output register
    assign stall      = cmp_valid_reg && hit && hold_valid_reg && !out_free;
    assign issue_more = (issue_reg != limit_reg);
    assign rd_en      = (state_reg == ST_SCAN) && issue_more && !stall;
    assign rd_addr    = issue_reg[IDX_W-1:0];

    always_comb
    begin
        state_next      = state_reg;
        limit_next      = limit_reg;
        issue_next      = issue_reg;
        cmp_valid_next  = cmp_valid_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        push            = '0;
        push.data.chrom = q_chrom_reg;
        push.data.start = q_start_reg;
        push.data.stop  = q_stop_reg;
        push.data.id    = hold_id_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (item.mode == ioa_pkg::MODE_QUERY))
                begin
                    limit_next      = clamp;
                    issue_next      = '0;
                    cmp_valid_next  = 1'b0;
                    hold_valid_next = 1'b0;
                    if (clamp != '0)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    issue_next = issue_reg + 1'b1;
                end
                if (!stall)
                begin
                    cmp_valid_next = rd_en;
                    if (cmp_valid_reg && hit)
                    begin
                        push.valid      = hold_valid_reg;
                        hold_valid_next = 1'b1;
                        hold_id_next    = rd_data.ent_id;
                    end
                end
                if (!issue_more && !cmp_valid_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!hold_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    push.valid      = 1'b1;
                    push.data.last  = 1'b1;
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            limit_reg      <= '0;
            issue_reg      <= '0;
            cmp_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            limit_reg      <= limit_next;
            issue_reg      <= issue_next;
            cmp_valid_reg  <= cmp_valid_next;
            hold_valid_reg <= hold_valid_next;
            if (cfg_wr_en)
            begin
                count_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        hold_id_reg <= hold_id_next;
        if (accept)
        begin
            q_start_reg <= item.range_start;
            q_stop_reg  <= item.range_end;
            q_chrom_reg <= item.region_chrom;
        end
    end

endmodule

// File: rtl/ioa_out_stage.sv
module ioa_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  ioa_pkg::push_t push,
    output logic           out_free,
    ioa_out_if.source      match
);

    logic             out_valid_reg, out_valid_next;
    ioa_pkg::result_t out_data_reg;

    assign out_free       = !out_valid_reg || match.ready;
    assign out_valid_next = push.valid ? 1'b1 : (match.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            out_data_reg <= push.data;
        end
    end

    assign match.valid      = out_valid_reg;
    assign match.out_chrom  = out_data_reg.chrom;
    assign match.out_start  = out_data_reg.start;
    assign match.out_end    = out_data_reg.stop;
    assign match.out_id     = out_data_reg.id;
    assign match.last_match = out_data_reg.last;

endmodule

// File: rtl/ioa_checker.sv
module ioa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        item_valid,
    input logic                        item_ready,
    input logic                        item_mode,
    input logic                        match_valid,
    input logic                        match_ready,
    input logic [ioa_pkg::ENTRY_W-1:0] match_id,
    input logic                        match_last
);

    // output register is empty while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !match_valid)
        else $error("result valid during reset");

    // a load never holds off the next input transfer
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && (item_mode == ioa_pkg::MODE_LOAD) |=> item_ready)
        else $error("input not ready after load");

    // once the block takes input again, any result still waiting closes its query
    a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
        item_ready && match_valid |-> match_last)
        else $error("unmarked result left over while idle");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        match_valid && !match_ready |=> match_valid && $stable(match_id) && $stable(match_last))
        else $error("stalled result changed");

endmodule

bind interval_overlap_annotator_top ioa_checker u_ioa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item.valid),
    .item_ready  (item.ready),
    .item_mode   (item.mode),
    .match_valid (match.valid),
    .match_ready (match.ready),
    .match_id    (match.out_id),
    .match_last  (match.last_match)
);
